// ===== hdl/cce_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cce_pkg: shared types and constants for the text console cursor engine
// Command encoding, queue entry layout, character codes and back-end states.
// ---------------------------------------------------------------------------
package cce_pkg;

    localparam int CHW  = 8;
    localparam int IDXW = 11;

    // Input action codes
    localparam logic [1:0] ACT_PRINT = 2'd0;
    localparam logic [1:0] ACT_CLEAR = 2'd1;
    localparam logic [1:0] ACT_READ  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    // Character codes
    localparam logic [CHW-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHW-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHW-1:0] CH_SPACE     = 8'h20;
    localparam logic [CHW-1:0] RESET_ATTR   = 8'h07;

    // Command queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPW         = $clog2(QUEUE_DEPTH);
    localparam int QCW         = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [2:0] {
        CMD_PUT,
        CMD_NEWLINE,
        CMD_BACKSPACE,
        CMD_CLEAR,
        CMD_READ,
        CMD_NOP
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t         op;
        logic [CHW-1:0]  char_code;
        logic [CHW-1:0]  attr;
        logic [IDXW-1:0] cell_index;
        logic [CHW-1:0]  blank_attr;
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_RDOUT,
        ST_FILL
    } back_state_t;

endpackage

`default_nettype wire

// ===== hdl/cce_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cce_front: input acceptance and command classification
// Holds the blank attribute register, decodes each transaction into a command.
// ---------------------------------------------------------------------------
module cce_front import cce_pkg::*; (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [CHW-1:0]  cfg_default_attr,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [1:0]      s_action,
    input  wire logic [CHW-1:0]  s_char_code,
    input  wire logic [CHW-1:0]  s_attr,
    input  wire logic [IDXW-1:0] s_cell_index,
    input  wire logic            q_full,
    input  wire logic            init_busy,
    output logic                 q_push,
    output cmd_t                 q_cmd
);

    logic [CHW-1:0] default_attr_reg;
    logic [CHW-1:0] default_attr_next;

    assign cfg_ready = 1'b1;
    assign s_ready   = !q_full && !init_busy;
    assign q_push    = s_valid && s_ready;

    always_comb begin
        default_attr_next = default_attr_reg;
        if (cfg_valid) begin
            default_attr_next = cfg_default_attr;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_attr_reg <= RESET_ATTR;
        end else begin
            default_attr_reg <= default_attr_next;
        end
    end

    always_comb begin
        q_cmd.char_code  = s_char_code;
        q_cmd.attr       = s_attr;
        q_cmd.cell_index = s_cell_index;
        q_cmd.blank_attr = default_attr_reg;
        case (s_action)
            ACT_PRINT: begin
                if (s_char_code == CH_NEWLINE) begin
                    q_cmd.op = CMD_NEWLINE;
                end else if (s_char_code == CH_BACKSPACE) begin
                    q_cmd.op = CMD_BACKSPACE;
                end else begin
                    q_cmd.op = CMD_PUT;
                end
            end
            ACT_CLEAR: begin
                q_cmd.op = CMD_CLEAR;
            end
            ACT_READ: begin
                q_cmd.op = CMD_READ;
            end
            default: begin
                q_cmd.op = CMD_NOP;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hdl/cce_cmd_fifo.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cce_cmd_fifo: short command queue between front and back
// Register-based FIFO; the head entry is presented combinationally.
// ---------------------------------------------------------------------------
module cce_cmd_fifo import cce_pkg::*; (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    output logic      full,
    output logic      head_valid,
    output cmd_t      head_cmd,
    input  wire logic pop
);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   count_reg, count_next;

    assign full       = (count_reg == QCW'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/cce_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cce_back: command execution, screen memory and result register
// Screen rows live in a ring; scrolling moves the base and blanks one row.
// ---------------------------------------------------------------------------
module cce_back import cce_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            q_valid,
    input  wire cmd_t            q_cmd,
    output logic                 q_pop,
    output logic                 init_busy,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [CHW-1:0]       m_read_char,
    output logic [CHW-1:0]       m_read_attr,
    output logic [IDXW-1:0]      m_cursor_pos
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int CW    = $clog2(CELLS + 1);
    localparam int COLW  = $clog2(COLUMNS);
    localparam int XW    = (AW + 1 > IDXW) ? AW + 1 : IDXW;

    localparam logic [AW-1:0]   LAST_CELL      = AW'(CELLS - 1);
    localparam logic [AW-1:0]   LAST_ROW_START = AW'(CELLS - COLUMNS);
    localparam logic [COLW-1:0] LAST_COL       = COLW'(COLUMNS - 1);
    localparam logic [CW-1:0]   CELLS_C        = CW'(CELLS);
    localparam logic [CW-1:0]   COLS_C         = CW'(COLUMNS);
    localparam logic [AW:0]     COLS_W         = (AW + 1)'(COLUMNS);
    localparam logic [AW:0]     CELLS_W        = (AW + 1)'(CELLS);
    localparam logic [XW-1:0]   CELLS_X        = XW'(CELLS);

    back_state_t      state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [AW-1:0]    cursor_reg, cursor_next;
    logic [COLW-1:0]  col_reg, col_next;
    logic [AW-1:0]    pcur_reg, pcur_next;
    logic [AW-1:0]    base_reg, base_next;
    logic [AW-1:0]    fill_addr_reg, fill_addr_next;
    logic [CW-1:0]    fill_cnt_reg, fill_cnt_next;
    logic             fill_res_reg, fill_res_next;
    logic [CHW-1:0]   blank_attr_reg, blank_attr_next;
    logic             in_range_reg, in_range_next;
    logic             m_valid_reg, m_valid_next;
    logic [CHW-1:0]   m_char_reg, m_char_next;
    logic [CHW-1:0]   m_attr_reg, m_attr_next;
    logic [IDXW-1:0]  m_pos_reg, m_pos_next;

    // screen memory, one write and one registered read per cycle
    logic [2*CHW-1:0] mem [CELLS];
    logic             mem_we;
    logic [AW-1:0]    mem_waddr;
    logic [2*CHW-1:0] mem_wdata;
    logic             mem_re;
    logic [AW-1:0]    mem_raddr;
    logic [2*CHW-1:0] rd_data_reg;

    logic [AW:0]      base_sum;
    logic [AW-1:0]    base_adv;
    logic [AW-1:0]    pcur_inc, pcur_dec;
    logic [COLW-1:0]  col_inc, col_dec;
    logic [XW-1:0]    rd_sum, rd_phys;
    logic             idx_ok;
    logic [2*CHW-1:0] blank_cell;
    logic             load_res;
    logic [CHW-1:0]   res_char, res_attr;

    assign m_valid      = m_valid_reg;
    assign m_read_char  = m_char_reg;
    assign m_read_attr  = m_attr_reg;
    assign m_cursor_pos = m_pos_reg;
    assign init_busy    = (state_reg == ST_FILL) && !fill_res_reg;

    assign blank_cell = {blank_attr_reg, CH_SPACE};
    assign base_sum   = {1'b0, base_reg} + COLS_W;
    assign base_adv   = (base_sum >= CELLS_W) ? AW'(base_sum - CELLS_W) : base_sum[AW-1:0];
    assign pcur_inc   = (pcur_reg == LAST_CELL) ? '0 : pcur_reg + 1'b1;
    assign pcur_dec   = (pcur_reg == '0) ? LAST_CELL : pcur_reg - 1'b1;
    assign col_inc    = (col_reg == LAST_COL) ? '0 : col_reg + 1'b1;
    assign col_dec    = (col_reg == '0) ? LAST_COL : col_reg - 1'b1;
    assign rd_sum     = XW'(cmd_reg.cell_index) + XW'(base_reg);
    assign rd_phys    = (rd_sum >= CELLS_X) ? rd_sum - CELLS_X : rd_sum;
    assign idx_ok     = XW'(cmd_reg.cell_index) < CELLS_X;
    assign mem_raddr  = rd_phys[AW-1:0];

    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        cursor_next     = cursor_reg;
        col_next        = col_reg;
        pcur_next       = pcur_reg;
        base_next       = base_reg;
        fill_addr_next  = fill_addr_reg;
        fill_cnt_next   = fill_cnt_reg;
        fill_res_next   = fill_res_reg;
        blank_attr_next = blank_attr_reg;
        in_range_next   = in_range_reg;
        q_pop           = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = pcur_reg;
        mem_wdata       = blank_cell;
        mem_re          = 1'b0;
        load_res        = 1'b0;
        res_char        = '0;
        res_attr        = '0;

        case (state_reg)
            ST_IDLE: begin
                if (q_valid && (!m_valid_reg || m_ready)) begin
                    q_pop           = 1'b1;
                    cmd_next        = q_cmd;
                    blank_attr_next = q_cmd.blank_attr;
                    state_next      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                case (cmd_reg.op)
                    CMD_PUT, CMD_NEWLINE: begin
                        mem_we    = 1'b1;
                        mem_waddr = pcur_reg;
                        if (cmd_reg.op == CMD_PUT) begin
                            mem_wdata = {cmd_reg.attr, cmd_reg.char_code};
                        end
                        if (cursor_reg == LAST_CELL) begin
                            // scroll: old top row becomes the blank bottom row
                            cursor_next    = LAST_ROW_START;
                            col_next       = '0;
                            pcur_next      = base_reg;
                            base_next      = base_adv;
                            fill_addr_next = base_reg;
                            fill_cnt_next  = COLS_C;
                            fill_res_next  = 1'b1;
                            state_next     = ST_FILL;
                        end else begin
                            cursor_next = cursor_reg + 1'b1;
                            col_next    = col_inc;
                            pcur_next   = pcur_inc;
                            if (cmd_reg.op == CMD_PUT || col_inc == '0) begin
                                load_res   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end
                    end
                    CMD_BACKSPACE: begin
                        if (cursor_reg != '0) begin
                            mem_we      = 1'b1;
                            mem_waddr   = pcur_dec;
                            cursor_next = cursor_reg - 1'b1;
                            col_next    = col_dec;
                            pcur_next   = pcur_dec;
                        end
                        load_res   = 1'b1;
                        state_next = ST_IDLE;
                    end
                    CMD_CLEAR: begin
                        cursor_next    = '0;
                        col_next       = '0;
                        pcur_next      = '0;
                        base_next      = '0;
                        fill_addr_next = '0;
                        fill_cnt_next  = CELLS_C;
                        fill_res_next  = 1'b1;
                        state_next     = ST_FILL;
                    end
                    CMD_READ: begin
                        mem_re        = 1'b1;
                        in_range_next = idx_ok;
                        state_next    = ST_RDOUT;
                    end
                    default: begin
                        load_res   = 1'b1;
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_RDOUT: begin
                load_res = 1'b1;
                if (in_range_reg) begin
                    res_char = rd_data_reg[CHW-1:0];
                    res_attr = rd_data_reg[2*CHW-1:CHW];
                end
                state_next = ST_IDLE;
            end
            ST_FILL: begin
                mem_we         = 1'b1;
                mem_waddr      = fill_addr_reg;
                fill_addr_next = fill_addr_reg + 1'b1;
                fill_cnt_next  = fill_cnt_reg - 1'b1;
                if (fill_cnt_reg == CW'(1)) begin
                    load_res   = fill_res_reg;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result register; only loaded when empty, see pop condition
    always_comb begin
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_attr_next  = m_attr_reg;
        m_pos_next   = m_pos_reg;
        if (load_res) begin
            m_valid_next = 1'b1;
            m_char_next  = res_char;
            m_attr_next  = res_attr;
            m_pos_next   = IDXW'(XW'(cursor_next));
        end else if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_FILL;
            cursor_reg     <= '0;
            col_reg        <= '0;
            pcur_reg       <= '0;
            base_reg       <= '0;
            fill_addr_reg  <= '0;
            fill_cnt_reg   <= CELLS_C;
            fill_res_reg   <= 1'b0;
            blank_attr_reg <= RESET_ATTR;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cursor_reg     <= cursor_next;
            col_reg        <= col_next;
            pcur_reg       <= pcur_next;
            base_reg       <= base_next;
            fill_addr_reg  <= fill_addr_next;
            fill_cnt_reg   <= fill_cnt_next;
            fill_res_reg   <= fill_res_next;
            blank_attr_reg <= blank_attr_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg      <= cmd_next;
        in_range_reg <= in_range_next;
        m_char_reg   <= m_char_next;
        m_attr_reg   <= m_attr_next;
        m_pos_reg    <= m_pos_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== hdl/text_console_cursor_engine.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// text_console_cursor_engine: text-mode console with a linear cursor
// Character/attribute screen memory, print, newline, backspace, scroll,
// clear and cell read.
// ---------------------------------------------------------------------------
// Usage:
//   s_* channel: one transaction per command (print, clear, read). Every
//   accepted transaction produces exactly one m_* transaction carrying the
//   cell read (zero unless a read) and the cursor after the command.
//   cfg_* channel: writes the blank attribute; always ready. Write it only
//   while no command is outstanding.
// Sequencing (from queue pop to result register load; the result shows on
//   m_* the cycle after; the next command is popped only after the load):
//   printable character, backspace or no-op: done in the execute state
//   read: the execute state issues the registered memory read, then the
//   readout state loads the result; newline: blanks written from the cursor
//   to the end of its row; scroll (last cell filled): a fill pass blanks the bottom row
//   clear: a fill pass over all COLUMNS*ROWS cells, one cell written per cycle
//   The screen memory has a single write port, so cells are written singly.
// Reset: a clearing pass over all cells writes blanks with attribute
//   7; s_ready stays low until it finishes.
// Stall: a two-entry command queue decouples the front from the execution
//   unit; when m_ready is low the result register holds and the queue fills,
//   after which s_ready drops.
// ---------------------------------------------------------------------------
module text_console_cursor_engine import cce_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            cfg_valid,
    output logic                 cfg_ready,
    input  wire logic [CHW-1:0]  cfg_default_attr,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [1:0]      s_action,
    input  wire logic [CHW-1:0]  s_char_code,
    input  wire logic [CHW-1:0]  s_attr,
    input  wire logic [IDXW-1:0] s_cell_index,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic [CHW-1:0]       m_read_char,
    output logic [CHW-1:0]       m_read_attr,
    output logic [IDXW-1:0]      m_cursor_pos
);

    // front -> queue
    logic q_push;
    cmd_t q_push_cmd;
    logic q_full;

    // queue -> back
    logic q_head_valid;
    cmd_t q_head_cmd;
    logic q_pop;

    // back busy with the post-reset clearing pass
    logic init_busy;

    cce_front u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_default_attr (cfg_default_attr),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_char_code      (s_char_code),
        .s_attr           (s_attr),
        .s_cell_index     (s_cell_index),
        .q_full           (q_full),
        .init_busy        (init_busy),
        .q_push           (q_push),
        .q_cmd            (q_push_cmd)
    );

    cce_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_cmd   (q_push_cmd),
        .full       (q_full),
        .head_valid (q_head_valid),
        .head_cmd   (q_head_cmd),
        .pop        (q_pop)
    );

    cce_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_head_valid),
        .q_cmd        (q_head_cmd),
        .q_pop        (q_pop),
        .init_busy    (init_busy),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_char  (m_read_char),
        .m_read_attr  (m_read_attr),
        .m_cursor_pos (m_cursor_pos)
    );

endmodule

`default_nettype wire

// ===== hdl/cce_checker.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// cce_checker: port-level checks for the console engine
// Reset behavior, result hold under stall and cursor range.
// ---------------------------------------------------------------------------
module cce_checker #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_ready,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_read_char,
    input wire logic [7:0]  m_read_attr,
    input wire logic [10:0] m_cursor_pos
);

    localparam int CELLS = COLUMNS * ROWS;

    // s_ready low right after reset, as the clearing pass begins
    a_ready_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("s_ready high right after reset");

    a_no_result_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("m_valid high right after reset");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cursor_pos)
            && $stable(m_read_char) && $stable(m_read_attr))
        else $error("result changed while stalled");

    a_cursor_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (32'(m_cursor_pos) < CELLS))
        else $error("cursor outside screen");

endmodule

bind text_console_cursor_engine cce_checker #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
) u_cce_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .s_ready      (s_ready),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_char  (m_read_char),
    .m_read_attr  (m_read_attr),
    .m_cursor_pos (m_cursor_pos)
);

`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb: self-checking bench for text_console_cursor_engine
// A short scripted sequence covers reset contents, field extremes, newline,
// backspace, clear and out-of-range reads. Randomized phases at several
// blank attributes follow; some are scroll-heavy, and the first one carries
// a long result hold-off while items keep coming. Each result is checked
// against its typed-in value or a shadow screen kept inside the bench.
// ---------------------------------------------------------------------------
module tb;
    import cce_pkg::*;

    localparam int COLS         = 80;
    localparam int ROW_COUNT    = 25;
    localparam int CELLS        = COLS * ROW_COUNT;
    localparam int HOLD_CYCLES  = 400;
    localparam int HOLD_AT_ITEM = 40;
    localparam int DRAIN_CYCLES = 200;
    localparam int CYCLE_LIMIT  = 1_000_000;

    typedef struct packed {
        logic [1:0]      action;
        logic [CHW-1:0]  char_code;
        logic [CHW-1:0]  attr;
        logic [IDXW-1:0] cell_index;
    } console_cmd_t;

    typedef struct packed {
        logic [CHW-1:0]  rd_char;
        logic [CHW-1:0]  rd_attr;
        logic [IDXW-1:0] cursor;
    } console_result_t;

    // A script row: the command, plus a typed-in result where it is obvious.
    typedef struct packed {
        console_cmd_t    cmd;
        logic            fixed;
        console_result_t result;
    } script_row_t;

    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_PERIODIC
    } rx_mode_t;

    // DUT interface
    logic            aclk;
    logic            aresetn;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [CHW-1:0]  cfg_default_attr;
    logic            s_valid;
    logic            s_ready;
    logic [1:0]      s_action;
    logic [CHW-1:0]  s_char_code;
    logic [CHW-1:0]  s_attr;
    logic [IDXW-1:0] s_cell_index;
    logic            m_valid;
    logic            m_ready;
    logic [CHW-1:0]  m_read_char;
    logic [CHW-1:0]  m_read_attr;
    logic [IDXW-1:0] m_cursor_pos;

    // Shadow of the console: screen, cursor and blank attribute
    logic [15:0]     shadow_screen [CELLS];
    int unsigned     shadow_cursor;
    logic [CHW-1:0]  shadow_blank_attr;

    console_result_t due_results [$];
    console_result_t head_result;
    script_row_t     script_rows [$];
    int              mismatches;
    int              cycle_count;

    // Receiver control
    logic            hold_req;
    logic            hold_taken  = 1'b0;
    int              hold_left   = 0;
    int              mode_left   = 0;
    rx_mode_t        stall_mode  = RX_OPEN;
    logic [7:0]      pattern_cnt = '0;

    text_console_cursor_engine #(
        .COLUMNS(COLS),
        .ROWS   (ROW_COUNT)
    ) u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_default_attr(cfg_default_attr),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_action        (s_action),
        .s_char_code     (s_char_code),
        .s_attr          (s_attr),
        .s_cell_index    (s_cell_index),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_read_char     (m_read_char),
        .m_read_attr     (m_read_attr),
        .m_cursor_pos    (m_cursor_pos)
    );

    initial aclk = 1'b0;
    always #4 aclk = ~aclk;

    // ------------------------------------------------------------------
    // Shadow console
    // ------------------------------------------------------------------
    function automatic logic [15:0] blank_cell();
        return {shadow_blank_attr, CH_SPACE};
    endfunction

    function automatic void blank_screen();
        int i;
        for (i = 0; i < CELLS; i++) shadow_screen[i] = blank_cell();
    endfunction

    // Store one cell at the cursor and advance; running off the last cell
    // scrolls everything up a row and blanks the bottom row.
    function automatic void shadow_put(input logic [CHW-1:0] ch, input logic [CHW-1:0] at);
        int i;
        shadow_screen[shadow_cursor] = {at, ch};
        shadow_cursor++;
        if (shadow_cursor >= CELLS) begin
            for (i = 0; i < CELLS - COLS; i++) shadow_screen[i] = shadow_screen[i + COLS];
            for (i = CELLS - COLS; i < CELLS; i++) shadow_screen[i] = blank_cell();
            shadow_cursor -= COLS;
        end
    endfunction

    function automatic console_result_t console_step(input console_cmd_t c);
        console_result_t r;
        r = '0;
        case (c.action)
            ACT_PRINT: begin
                if (c.char_code == CH_NEWLINE) begin
                    // always at least one blank, so column 0 pads a full row
                    shadow_put(CH_SPACE, shadow_blank_attr);
                    while (shadow_cursor % COLS != 0) shadow_put(CH_SPACE, shadow_blank_attr);
                end else if (c.char_code == CH_BACKSPACE) begin
                    if (shadow_cursor > 0) begin
                        shadow_cursor--;
                        shadow_screen[shadow_cursor] = blank_cell();
                    end
                end else begin
                    shadow_put(c.char_code, c.attr);
                end
            end
            ACT_CLEAR: begin
                blank_screen();
                shadow_cursor = 0;
            end
            ACT_READ: begin
                if (c.cell_index < CELLS) {r.rd_attr, r.rd_char} = shadow_screen[c.cell_index];
            end
            default: ;
        endcase
        r.cursor = IDXW'(shadow_cursor);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_row(input logic [1:0] act, input logic [CHW-1:0] ch,
                                    input logic [CHW-1:0] at, input logic [IDXW-1:0] idx,
                                    input logic fixed, input logic [CHW-1:0] rc,
                                    input logic [CHW-1:0] ra, input logic [IDXW-1:0] cur);
        script_row_t row;
        row.cmd.action     = act;
        row.cmd.char_code  = ch;
        row.cmd.attr       = at;
        row.cmd.cell_index = idx;
        row.fixed          = fixed;
        row.result.rd_char = rc;
        row.result.rd_attr = ra;
        row.result.cursor  = cur;
        script_rows.push_back(row);
    endfunction

    // Random command. nl_pct: share of prints that are newlines;
    // clr_per200: clear rate out of 200.
    function automatic console_cmd_t pick_cmd(input int nl_pct, input int clr_per200);
        console_cmd_t c;
        int sel;
        c.attr       = 8'($urandom_range(0, 255));
        c.char_code  = 8'($urandom_range(0, 255));
        c.cell_index = 11'($urandom_range(0, 2047));
        sel = $urandom_range(0, 199);
        if (sel < clr_per200) begin
            c.action = ACT_CLEAR;
        end else if (sel < clr_per200 + 4) begin
            c.action = ACT_NONE;
        end else if (sel < 60) begin
            c.action = ACT_READ;
            sel = $urandom_range(0, 99);
            if (sel < 6)
                c.cell_index = 11'($urandom_range(CELLS, 2047));
            else if (sel < 35 && shadow_cursor > 2)
                c.cell_index = 11'(shadow_cursor - $urandom_range(0, 2));
            else
                c.cell_index = 11'($urandom_range(0, CELLS - 1));
        end else begin
            c.action = ACT_PRINT;
            sel = $urandom_range(0, 99);
            if (sel < nl_pct)
                c.char_code = CH_NEWLINE;
            else if (sel < nl_pct + 8)
                c.char_code = CH_BACKSPACE;
        end
        return c;
    endfunction

    // One command transaction; the expectation is queued at acceptance.
    task automatic send_cmd(input console_cmd_t c, input logic fixed,
                            input console_result_t typed);
        console_result_t pred;
        s_valid      <= 1'b1;
        s_action     <= c.action;
        s_char_code  <= c.char_code;
        s_attr       <= c.attr;
        s_cell_index <= c.cell_index;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pred = console_step(c);
        due_results.push_back(fixed ? typed : pred);
    endtask

    task automatic wait_drained();
        while (due_results.size() != 0) @(posedge aclk);
    endtask

    task automatic write_blank_attr(input logic [CHW-1:0] value);
        cfg_valid        <= 1'b1;
        cfg_default_attr <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid         <= 1'b0;
        shadow_blank_attr = value;
    endtask

    // Randomized phase. lead_newlines pushes the cursor onto the bottom row
    // first so that plain printing runs into the scroll. with_hold asks the
    // receiver for its long hold-off partway in, while items keep coming.
    task automatic run_phase(input logic [CHW-1:0] blank_attr, input int n, input int nl_pct,
                             input int clr_per200, input int lead_newlines,
                             input logic with_hold);
        console_cmd_t c;
        int burst_left;
        int gap;
        int k;
        wait_drained();
        write_blank_attr(blank_attr);
        burst_left = 0;
        for (k = 0; k < n; k++) begin
            if (with_hold && k == HOLD_AT_ITEM) hold_req <= 1'b1;
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
                if (gap != 0) begin
                    s_valid <= 1'b0;
                    repeat (gap) @(posedge aclk);
                end
            end
            burst_left--;
            c = pick_cmd(nl_pct, clr_per200);
            if (k < lead_newlines) begin
                c.action    = ACT_PRINT;
                c.char_code = CH_NEWLINE;
            end
            send_cmd(c, 1'b0, '0);
        end
        s_valid <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Result side: stall patterns, plus one long hold-off on request so
    // the command queue fills and s_ready drops.
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left  <= HOLD_CYCLES;
            m_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            if (mode_left == 0) begin
                stall_mode <= rx_mode_t'($urandom_range(0, 3));
                mode_left  <= $urandom_range(64, 256);
            end else begin
                mode_left <= mode_left - 1;
            end
            case (stall_mode)
                RX_OPEN:     m_ready <= 1'b1;
                RX_COIN:     m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE:   m_ready <= ($urandom_range(0, 7) != 0);
                RX_PERIODIC: m_ready <= (pattern_cnt[2:0] < 3'd5);
                default:     m_ready <= 1'b1;
            endcase
            pattern_cnt <= pattern_cnt + 8'd1;
        end
    end

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
            mismatches++;
        end
    endfunction

    // Compare each result transaction with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got char 0x%0h attr 0x%0h cursor %0d",
                         $time, m_read_char, m_read_attr, m_cursor_pos);
                mismatches++;
            end else begin
                head_result = due_results.pop_front();
                check_field("read_char", head_result.rd_char, m_read_char);
                check_field("read_attr", head_result.rd_attr, m_read_attr);
                check_field("cursor_pos", head_result.cursor, m_cursor_pos);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("[text_console_cursor_engine] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial begin
        int r;
        mismatches       = 0;
        cycle_count      = 0;
        hold_req         = 1'b0;
        m_ready          = 1'b0;
        cfg_valid        = 1'b0;
        cfg_default_attr = RESET_ATTR;
        s_valid          = 1'b0;
        s_action         = ACT_NONE;
        s_char_code      = '0;
        s_attr           = '0;
        s_cell_index     = '0;
        aresetn          = 1'b0;
        shadow_blank_attr = RESET_ATTR;
        shadow_cursor     = 0;
        blank_screen();

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // Scripted part; s_ready stays low through the clearing pass.
        //      action     char          attr   index  fixed  rchar  rattr  cursor
        add_row(ACT_READ,  8'h00,        8'h00, 11'd0,    1, 8'h20, 8'h07, 11'd0);
        add_row(ACT_READ,  8'h00,        8'h00, 11'd1999, 1, 8'h20, 8'h07, 11'd0);
        add_row(ACT_READ,  8'hFF,        8'hFF, 11'd2047, 1, 8'h00, 8'h00, 11'd0);
        add_row(ACT_NONE,  8'hFF,        8'hFF, 11'd2047, 1, 8'h00, 8'h00, 11'd0);
        add_row(ACT_PRINT, CH_BACKSPACE, 8'hFF, 11'd0,    1, 8'h00, 8'h00, 11'd0);
        add_row(ACT_PRINT, 8'h41,        8'hFF, 11'd0,    1, 8'h00, 8'h00, 11'd1);
        add_row(ACT_PRINT, 8'hFF,        8'h00, 11'd2047, 1, 8'h00, 8'h00, 11'd2);
        add_row(ACT_PRINT, 8'h00,        8'h80, 11'd1024, 1, 8'h00, 8'h00, 11'd3);
        add_row(ACT_READ,  8'h00,        8'h00, 11'd0,    1, 8'h41, 8'hFF, 11'd3);
        add_row(ACT_READ,  8'h00,        8'h00, 11'd1,    1, 8'hFF, 8'h00, 11'd3);
        add_row(ACT_READ,  8'h00,        8'h00, 11'd2,    1, 8'h00, 8'h80, 11'd3);
        add_row(ACT_PRINT, CH_NEWLINE,   8'h55, 11'd0,    1, 8'h00, 8'h00, 11'd80);
        add_row(ACT_READ,  8'h00,        8'h00, 11'd3,    1, 8'h20, 8'h07, 11'd80);
        // newline at column zero pads a whole row
        add_row(ACT_PRINT, CH_NEWLINE,   8'h00, 11'd0,    1, 8'h00, 8'h00, 11'd160);
        // backspace at column zero steps back into the row above
        add_row(ACT_PRINT, CH_BACKSPACE, 8'h00, 11'd0,    1, 8'h00, 8'h00, 11'd159);
        add_row(ACT_PRINT, 8'h7A,        8'h3C, 11'd0,    0, 8'h00, 8'h00, 11'd0);
        add_row(ACT_READ,  8'h00,        8'h00, 11'd159,  0, 8'h00, 8'h00, 11'd0);
        add_row(ACT_PRINT, CH_BACKSPACE, 8'h00, 11'd0,    0, 8'h00, 8'h00, 11'd0);
        add_row(ACT_READ,  8'h00,        8'h00, 11'd159,  1, 8'h20, 8'h07, 11'd159);
        add_row(ACT_CLEAR, 8'h00,        8'h00, 11'd0,    1, 8'h00, 8'h00, 11'd0);
        add_row(ACT_READ,  8'h00,        8'h00, 11'd0,    1, 8'h20, 8'h07, 11'd0);
        add_row(ACT_READ,  8'h00,        8'h00, 11'd80,   1, 8'h20, 8'h07, 11'd0);

        for (r = 0; r < script_rows.size(); r++)
            send_cmd(script_rows[r].cmd, script_rows[r].fixed, script_rows[r].result);
        s_valid <= 1'b0;

        // Random phases: blank attribute, items, newline %, clears, lead-in,
        // long hold-off. Only the first one asks for the hold-off.
        run_phase(8'h00, 260, 15, 3, 0, 1'b1);
        run_phase(8'hFF, 260, 1, 0, 24, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 260, 10, 3, 0, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 260, 1, 0, 24, 1'b0);
        run_phase(8'($urandom_range(0, 255)), 260, 25, 2, 0, 1'b0);

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("[text_console_cursor_engine] OK");
        else
            $display("[text_console_cursor_engine] ERROR");
        $finish;
    end

endmodule
